[design/poly_eval_mean_abs_error_defines.svh]
// Assertion macros shared by the block's modules.
`ifndef POLY_EVAL_MEAN_ABS_ERROR_DEFINES_SVH
`define POLY_EVAL_MEAN_ABS_ERROR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PEM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PEM_ASSERT_ONEHOT(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) $onehot(sig)) else $error(msg);
`else
`define PEM_ASSERT(label, clk, rst_n, prop, msg)
`define PEM_ASSERT_ONEHOT(label, clk, rst_n, sig, msg)
`endif
`endif

[design/pem_pkg.sv]
`timescale 1ns / 1ps
package pem_pkg;

  localparam int unsigned CoefW = 48;
  localparam int unsigned DataW = 32;
  localparam int unsigned SumW  = 48;

  // Configuration register indexes.
  localparam logic [2:0] RegCoef0  = 3'd0;
  localparam logic [2:0] RegCoef1  = 3'd1;
  localparam logic [2:0] RegCoef2  = 3'd2;
  localparam logic [2:0] RegCoef3  = 3'd3;
  localparam logic [2:0] RegDegree = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the point, load the top coefficient
    logic mul;       // register the low half of the acc * x magnitude product
    logic mul_hi;    // register the high half of the acc * x magnitude product
    logic add;       // finish one Horner step
    logic finish;    // form fitted value and error, update sum and count
    logic div_start; // start the mean division
    logic div_step;  // one bit of the restoring division
    logic out_load;  // move the result into the output register
  } pem_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic steps_left; // Horner steps remain
    logic last;       // captured point closes the set
    logic div_done;   // division finished
  } pem_sts_t;

endpackage

[design/pem_if.sv]
`timescale 1ns / 1ps
interface pem_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_value;
  logic [31:0] y_value;
  logic        last_point;
  modport source (output valid, x_value, y_value, last_point, input ready);
  modport sink   (input valid, x_value, y_value, last_point, output ready);
endinterface

interface pem_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] fitted_value;
  logic [31:0] point_error;
  logic [31:0] mean_error;
  logic        set_done;
  modport source (output valid, fitted_value, point_error, mean_error, set_done,
                  input ready);
  modport sink   (input valid, fitted_value, point_error, mean_error, set_done,
                  output ready);
endinterface

interface pem_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/pem_ctrl.sv]
`timescale 1ns / 1ps
`include "poly_eval_mean_abs_error_defines.svh"
module pem_ctrl
  import pem_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_busy_i,
  input  pem_sts_t sts_i,
  output pem_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StMul    = 7'b0000010,
    StMulHi  = 7'b0000100,
    StAdd    = 7'b0001000,
    StFinish = 7'b0010000,
    StDiv    = 7'b0100000,
    StOut    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // A new point enters only when no work is in flight.
  assign in_ready_o = (state_q == StIdle);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StMul;
        end
      end
      StMul: begin
        if (sts_i.steps_left) begin
          cmd_o.mul = 1'b1;
          state_d   = StMulHi;
        end else begin
          state_d = StFinish;
        end
      end
      StMulHi: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = StAdd;
      end
      StAdd: begin
        cmd_o.add = 1'b1;
        state_d   = StMul;
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        if (sts_i.last) begin
          cmd_o.div_start = 1'b1;
          state_d         = StDiv;
        end else begin
          state_d = StOut;
        end
      end
      StDiv: begin
        if (sts_i.div_done) begin
          state_d = StOut;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StOut: begin
        if (!out_busy_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `PEM_ASSERT_ONEHOT(a_state_onehot, clk_i, rst_ni, state_q, "state register not one-hot")
  `PEM_ASSERT(a_load_from_idle, clk_i, rst_ni, cmd_o.load |=> (state_q == StMul), "load did not start evaluation")
  `PEM_ASSERT(a_out_to_idle, clk_i, rst_ni, cmd_o.out_load |=> in_ready_o, "output did not free the input")

endmodule

[design/pem_datapath.sv]
`timescale 1ns / 1ps
`include "poly_eval_mean_abs_error_defines.svh"
module pem_datapath
  import pem_pkg::*;
#(
  parameter int unsigned MaxDegree = 3,
  parameter int unsigned MaxPoints = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pem_cmd_t          cmd_i,
  output pem_sts_t          sts_o,
  input  logic [31:0]       x_i,
  input  logic [31:0]       y_i,
  input  logic              last_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [CoefW-1:0]  cfg_data_i,
  output logic [31:0]       fit_o,
  output logic [31:0]       err_o,
  output logic [31:0]       mean_o,
  output logic              done_o
);

  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned EffDeg = (MaxDegree < 3) ? MaxDegree : 3;

  logic signed [CoefW-1:0] coef_q [4];
  logic [1:0]              degree_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) coef_q[i] <= '0;
      degree_q <= 2'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCoef0:  coef_q[0] <= cfg_data_i;
        RegCoef1:  coef_q[1] <= cfg_data_i;
        RegCoef2:  coef_q[2] <= cfg_data_i;
        RegCoef3:  coef_q[3] <= cfg_data_i;
        RegDegree: degree_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic [1:0] deg_eff;
  assign deg_eff = (32'(degree_q) > EffDeg) ? 2'(EffDeg) : degree_q;

  // Point capture and Horner accumulator.
  logic signed [31:0]      x_q, y_q;
  logic                    last_q;
  logic signed [CoefW-1:0] acc_q;
  logic [1:0]              step_q;  // coefficient index to add next, plus one
  logic                    neg_q;
  logic [55:0]             prod_lo_q, prod_hi_q;

  logic [47:0] acc_mag;
  logic [31:0] x_mag;
  assign acc_mag = acc_q[47] ? 48'(-acc_q) : acc_q;
  assign x_mag   = x_q[31] ? 32'(-x_q) : x_q;

  // The two 24 by 32 bit partial products are combined, shifted, clamped to
  // 2^47, then signed and added.
  logic [63:0]       pshift;
  logic [47:0]       pclamp;
  logic signed [49:0] sum50;
  logic signed [47:0] acc_new;
  assign pshift  = {prod_hi_q, 8'd0} + 64'(prod_lo_q >> 16);
  assign pclamp  = (pshift > 64'h8000_0000_0000) ? 48'h8000_0000_0000 : pshift[47:0];
  assign sum50   = (neg_q ? -$signed({2'b00, pclamp}) : $signed({2'b00, pclamp}))
                   + 50'(coef_q[step_q - 2'd1]);
  assign acc_new = (sum50 > 50'sh7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF :
                   (sum50 < -50'sh8000_0000_0000) ? 48'sh8000_0000_0000 : sum50[47:0];

  // Fitted value and point error.
  logic [47:0]        fmag;
  logic signed [31:0] fit;
  logic signed [32:0] diff;
  logic [31:0]        err;
  assign fmag = acc_mag >> 16;
  assign fit  = acc_q[47] ? -$signed(fmag[31:0]) : $signed(fmag[31:0]);
  assign diff = 33'(fit) - 33'(y_q);
  assign err  = diff[32] ? 32'(-diff) : diff[31:0];

  logic [SumW-1:0] sum_q;
  logic [CntW-1:0] cnt_q;
  logic [SumW:0]   sum_add;
  assign sum_add = {1'b0, sum_q} + (SumW+1)'(err);

  logic [31:0] fit_q, err_q;

  // Restoring divider: sum / count, one quotient bit a cycle.
  logic [SumW-1:0] dvd_q, quo_q;
  logic [CntW:0]   rem_q;
  logic [CntW-1:0] dvs_q;
  logic [5:0]      dcnt_q;
  logic [CntW:0]   rem_try;
  assign rem_try = {rem_q[CntW-1:0], dvd_q[SumW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      step_q <= '0;
      last_q <= 1'b0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        x_q    <= x_i;
        y_q    <= y_i;
        last_q <= last_i;
        acc_q  <= coef_q[deg_eff];
        step_q <= deg_eff;
      end
      if (cmd_i.mul) begin
        prod_lo_q <= acc_mag[23:0] * x_mag;
        neg_q     <= acc_q[47] ^ x_q[31];
      end
      if (cmd_i.mul_hi) begin
        prod_hi_q <= acc_mag[47:24] * x_mag;
      end
      if (cmd_i.add) begin
        acc_q  <= acc_new;
        step_q <= step_q - 2'd1;
      end
      if (cmd_i.finish) begin
        fit_q <= fit;
        err_q <= err;
        if (last_q) begin
          sum_q <= '0;
          cnt_q <= '0;
        end else begin
          sum_q <= sum_add[SumW] ? '1 : sum_add[SumW-1:0];
          if (cnt_q < CntW'(MaxPoints)) cnt_q <= cnt_q + 1'b1;
        end
      end
      if (cmd_i.div_start) begin
        dvd_q  <= sum_add[SumW] ? '1 : sum_add[SumW-1:0];
        dvs_q  <= (cnt_q < CntW'(MaxPoints)) ? cnt_q + 1'b1 : cnt_q;
        rem_q  <= '0;
        quo_q  <= '0;
        dcnt_q <= 6'(SumW);
      end
      if (cmd_i.div_step) begin
        dvd_q  <= dvd_q << 1;
        dcnt_q <= dcnt_q - 1'b1;
        if (rem_try >= {1'b0, dvs_q}) begin
          rem_q <= rem_try - {1'b0, dvs_q};
          quo_q <= {quo_q[SumW-2:0], 1'b1};
        end else begin
          rem_q <= rem_try;
          quo_q <= {quo_q[SumW-2:0], 1'b0};
        end
      end
    end
  end

  assign sts_o.steps_left = (step_q != 2'd0);
  assign sts_o.last       = last_q;
  assign sts_o.div_done   = (dcnt_q == 6'd0);

  assign fit_o  = fit_q;
  assign err_o  = err_q;
  assign mean_o = last_q ? ((quo_q[SumW-1:32] != '0) ? 32'hFFFF_FFFF : quo_q[31:0]) : 32'd0;
  assign done_o = last_q;

  `PEM_ASSERT(a_div_only_last, clk_i, rst_ni, cmd_i.div_start |-> last_q, "division outside set end")
  `PEM_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(MaxPoints), "count above limit")
  `PEM_ASSERT(a_div_nonzero, clk_i, rst_ni, cmd_i.div_step |-> (dvs_q != '0), "division by zero count")

endmodule

[design/poly_eval_mean_abs_error.sv]
`timescale 1ns / 1ps
// Evaluates a polynomial of degree up to three (Q16.32 coefficients) at each
// Q16.16 point by Horner's rule and returns the fitted value, the absolute
// error against y and, on the point marked last, the mean absolute error of
// the set. Each Horner step uses a 24 by 32 bit multiply twice (low and
// high half of the accumulator) and then the adder, before the result moves
// into the output register; a last point first runs the bit-serial division
// of the error sum by the point count. One point is in work at a time; the output
// register frees the datapath once loaded.
module poly_eval_mean_abs_error
  import pem_pkg::*;
#(
  parameter int unsigned MaxDegree = 3,
  parameter int unsigned MaxPoints = 65536
) (
  input  logic clk_i,
  input  logic rst_ni,
  pem_in_if.sink    in_if,
  pem_out_if.source out_if,
  pem_cfg_if.sink   cfg_if
);

  pem_cmd_t cmd;
  pem_sts_t sts;
  logic [31:0] fit, err, mean;
  logic        done, out_valid_q;

  assign cfg_if.ready = 1'b1;

  pem_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_busy_i (out_valid_q & ~out_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pem_datapath #(.MaxDegree(MaxDegree), .MaxPoints(MaxPoints)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .sts_o      (sts),
    .x_i        (in_if.x_value),
    .y_i        (in_if.y_value),
    .last_i     (in_if.last_point),
    .cfg_we_i   (cfg_if.valid),
    .cfg_idx_i  (cfg_if.index),
    .cfg_data_i (cfg_if.data),
    .fit_o      (fit),
    .err_o      (err),
    .mean_o     (mean),
    .done_o     (done)
  );

  // Output register holds one result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_if.fitted_value <= fit;
      out_if.point_error  <= err;
      out_if.mean_error   <= mean;
      out_if.set_done     <= done;
    end
  end

  assign out_if.valid = out_valid_q;

endmodule

[test/pem_tb_if.sv]
`timescale 1ns / 1ps
// The channel interfaces come with the RTL in pem_if.sv. This file keeps the
// testbench's shared types, so the file order stays package, interfaces, top.
package pem_tb_pkg;

  // One expected output beat.
  typedef struct packed {
    logic [31:0] fitted_value;
    logic [31:0] point_error;
    logic [31:0] mean_error;
    logic        set_done;
  } fit_result_t;

endpackage

[test/poly_eval_mean_abs_error_tb.sv]
`timescale 1ns / 1ps
module poly_eval_mean_abs_error_tb;
  import pem_pkg::*;
  import pem_tb_pkg::*;

  localparam int unsigned MaxPoints = 65536;
  localparam int unsigned WatchdogLimit = 20000;
  localparam logic signed [47:0] S48Max = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48Min = -48'sh8000_0000_0000;

  // Predicts each point's fit, error and set mean, and keeps the results due.
  class fit_scoreboard;
    logic signed [47:0] coef [4];
    logic [1:0]         degree;
    logic [47:0]        err_sum;
    int unsigned        pt_count;
    fit_result_t        pending [$];
    int unsigned        errors;

    function new();
      for (int i = 0; i < 4; i++) coef[i] = '0;
      degree   = 2'd3;
      err_sum  = '0;
      pt_count = 0;
      errors   = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] data);
      if (idx <= RegCoef3) coef[idx] = data;
      else if (idx == RegDegree) degree = data[1:0];
    endfunction

    // trunc0((acc * x) >> 16), clamped to 2^47 in magnitude.
    function logic signed [63:0] mul_shift(logic signed [47:0] acc,
                                           logic signed [31:0] x);
      logic [47:0] ma;
      logic [31:0] mx;
      logic [95:0] p;
      logic [79:0] q;
      logic        neg;
      neg = acc[47] ^ x[31];
      ma = acc[47] ? -acc : acc;
      mx = x[31] ? -x : x;
      p = ma * mx;
      q = p >> 16;
      if (q > 80'h8000_0000_0000) q = 80'h8000_0000_0000;
      return neg ? -$signed({16'd0, q[47:0]}) : $signed({16'd0, q[47:0]});
    endfunction

    function void note_point(logic [31:0] xv, logic [31:0] yv, logic last);
      logic signed [63:0] acc, fit, diff;
      logic [63:0]        mag, err, sum, mean;
      fit_result_t        r;
      acc = coef[degree];
      for (int i = int'(degree) - 1; i >= 0; i--) begin
        acc = mul_shift(acc[47:0], xv) + coef[i];
        if (acc > S48Max) acc = S48Max;
        if (acc < S48Min) acc = S48Min;
      end
      mag = acc < 0 ? -acc : acc;
      mag = mag >> 16;
      fit = acc < 0 ? -$signed(mag) : $signed(mag);
      diff = fit - $signed({{32{yv[31]}}, yv});
      err = diff < 0 ? -diff : diff;
      if (err > 64'hFFFF_FFFF) err = 64'hFFFF_FFFF;
      sum = {16'd0, err_sum} + err;
      err_sum = sum > 64'hFFFF_FFFF_FFFF ? 48'hFFFF_FFFF_FFFF : sum[47:0];
      if (pt_count < MaxPoints) pt_count++;
      mean = 0;
      if (last) begin
        mean = {16'd0, err_sum} / pt_count;
        if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
        err_sum  = '0;
        pt_count = 0;
      end
      r.fitted_value = fit[31:0];
      r.point_error  = err[31:0];
      r.mean_error   = mean[31:0];
      r.set_done     = last;
      pending.push_back(r);
    endfunction

    function void check_result(fit_result_t act);
      fit_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, act);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (act.fitted_value !== exp_r.fitted_value) begin
        $display("%0t: fitted_value expected %h actual %h", $time,
                 exp_r.fitted_value, act.fitted_value);
        errors++;
      end
      if (act.point_error !== exp_r.point_error) begin
        $display("%0t: point_error expected %h actual %h", $time,
                 exp_r.point_error, act.point_error);
        errors++;
      end
      if (act.mean_error !== exp_r.mean_error) begin
        $display("%0t: mean_error expected %h actual %h", $time,
                 exp_r.mean_error, act.mean_error);
        errors++;
      end
      if (act.set_done !== exp_r.set_done) begin
        $display("%0t: set_done expected %b actual %b", $time,
                 exp_r.set_done, act.set_done);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  pem_in_if  pt_ch ();
  pem_out_if res_ch ();
  pem_cfg_if reg_ch ();

  poly_eval_mean_abs_error dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (pt_ch.sink),
    .out_if (res_ch.source),
    .cfg_if (reg_ch.sink)
  );

  fit_scoreboard sb = new();
  int unsigned   idle_cycles = 0;
  bit            stim_done = 1'b0;

  initial begin
    pt_ch.valid = 1'b0;
    pt_ch.x_value = '0;
    pt_ch.y_value = '0;
    pt_ch.last_point = 1'b0;
    reg_ch.valid = 1'b0;
    reg_ch.index = '0;
    reg_ch.data = '0;
    res_ch.ready = 1'b0;
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk_i) begin
    if ((pt_ch.valid && pt_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (reg_ch.valid && reg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Result side: random stalls, check each beat. Ready only drops when a
  // stall is drawn, so it is driven once per time step.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      sb.check_result({res_ch.fitted_value, res_ch.point_error,
                       res_ch.mean_error, res_ch.set_done});
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] data);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= data;
    do @(posedge clk_i); while (!reg_ch.ready);
    sb.write_reg(idx, data);
    reg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_point(logic [31:0] xv, logic [31:0] yv, logic last,
                            bit gaps);
    if (gaps) repeat ($urandom_range(0, 6)) @(posedge clk_i);
    pt_ch.valid      <= 1'b1;
    pt_ch.x_value    <= xv;
    pt_ch.y_value    <= yv;
    pt_ch.last_point <= last;
    do @(posedge clk_i); while (!pt_ch.ready);
    sb.note_point(xv, yv, last);
    pt_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits for all results and the division tail before a register write.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand_coef(int unsigned span);
    logic [47:0] v;
    v = {$urandom(), $urandom()};
    case (span)
      0: v = {{33{v[15]}}, v[14:0]};
      1: v = {{17{v[31]}}, v[30:0]};
      2: v = {{9{v[39]}}, v[38:0]};
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_x();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 3))
      0: v = {{16{v[31]}}, v[15:0]};
      1: v = {{12{v[31]}}, v[19:0]};
      default: ;
    endcase
    return v;
  endfunction

  // Stimulus: directed extremes, then random sets over several settings.
  initial begin
    logic [31:0] xs [6];
    int unsigned setlen, span;
    bit          gaps;
    xs = '{32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
           32'h0001_0000};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients give zero fits; the error is |y|.
    send_point(32'h0, 32'h8000_0000, 1'b0, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
    drain();

    // Extreme coefficients: saturation of the accumulator and of the error.
    write_reg(RegCoef0, 48'h7FFF_FFFF_FFFF);
    write_reg(RegCoef1, 48'h8000_0000_0000);
    write_reg(RegCoef2, 48'h7FFF_FFFF_FFFF);
    write_reg(RegCoef3, 48'h8000_0000_0000);
    write_reg(RegDegree, 48'd3);
    foreach (xs[i]) send_point(xs[i], 32'h8000_0000, 1'b0, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
    drain();

    // Constant polynomial: x = 0 gives the constant term; single-point set.
    write_reg(RegDegree, 48'd0);
    write_reg(RegCoef0, 48'hFFFF_8000_0000);
    send_point(32'h0, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_point(32'h1234_5678, 32'h0, 1'b0, 1'b0);
    send_point(32'hFFFF_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
    drain();
    write_reg(RegDegree, 48'd1);
    write_reg(RegCoef1, 48'h0001_0000_0000);
    foreach (xs[i]) send_point(xs[i], ~xs[i], i == 5, 1'b0);
    drain();

    // Random sets; each phase picks a new register setting.
    for (int phase = 0; phase < 16; phase++) begin
      span = $urandom_range(0, 3);
      for (int r = 0; r < 4; r++) write_reg(r[2:0], rand_coef(span));
      write_reg(RegDegree, 48'($urandom_range(0, 3)));
      gaps = (phase % 4) != 3;
      for (int s = 0; s < 10; s++) begin
        setlen = $urandom_range(1, 20);
        for (int k = 0; k < setlen; k++) begin
          send_point(rand_x(), $urandom(), k == setlen - 1, gaps);
        end
      end
      drain();
    end
    stim_done = 1'b1;
  end

  // End of run.
  initial begin
    wait (stim_done);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/pem_pkg.sv
design/pem_if.sv
design/pem_ctrl.sv
design/pem_datapath.sv
design/poly_eval_mean_abs_error.sv
test/pem_tb_if.sv
test/poly_eval_mean_abs_error_tb.sv
